### src/range_to_fixed_point_format_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the range to fixed-point format block
// Each macro expands to a labeled concurrent assertion, or to nothing.
// ----------------------------------------------------------------------------
`ifndef RANGE_TO_FIXED_POINT_FORMAT_MACROS_SVH
`define RANGE_TO_FIXED_POINT_FORMAT_MACROS_SVH
`ifndef SYNTHESIS
`define RFF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RFF_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RFF_ASSERT_IMP(label, clk, rst, ante, cons)
`define RFF_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### src/rff_pkg.sv
// ----------------------------------------------------------------------------
// rff_pkg
// Shared types, codes and constants of the fixed-point format selector.
// ----------------------------------------------------------------------------
package rff_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAXW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NAN       = 3'd1;
  localparam logic [2:0] ST_INF       = 3'd2;
  localparam logic [2:0] ST_SHORT_INT = 3'd3;
  localparam logic [2:0] ST_SHORT_FRC = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_SCAN, S_INIT, S_LOOP, S_DONE, S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic scan;
    logic init;
    logic grow;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic special;
    logic scan_done;
    logic need_grow;
  } sts_t;

endpackage

### src/rff_datapath.sv
// ----------------------------------------------------------------------------
// rff_datapath
// Operand registers, bit scans, integer-bit count and width search.
// ----------------------------------------------------------------------------
module rff_datapath
  import rff_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [63:0] in_min,
  input  logic [63:0] in_max,
  input  logic [6:0]  start_bits,
  input  logic [7:0]  thr_raw,
  input  logic [6:0]  maxw,
  input  logic [6:0]  step_raw,
  output logic [22:0] result
);
`include "range_to_fixed_point_format_macros.svh"

  logic [63:0] bmin, bmax;
  logic [62:0] mag;
  logic        sgn, nan_f, inf_f, eq_f;
  logic [5:0]  scan_pos;
  logic [6:0]  tz;          // trailing zeros of significand
  logic        tz_hit;
  logic [6:0]  blen;        // bit length of subnormal fraction
  logic [12:0] int_bits, frac, neg_int;
  logic [7:0]  bits;
  logic [2:0]  status;
  logic        outsgn;

  logic [10:0] ef;
  logic [51:0] mf;
  assign ef = mag[62:52];
  assign mf = mag[51:0];

  logic signed [12:0] thr_s;
  assign thr_s = {{5{thr_raw[7]}}, thr_raw};
  logic [7:0] step_w;
  assign step_w = (step_raw == 7'd0) ? 8'd1 : {1'b0, step_raw};

  // ceil(log2(mag + 1)) with mag + 1 rounded to nearest even.
  // mag <= 2^-53: y rounds to 1 -> 0. mag < 1 otherwise -> 1.
  // exponent k in 0..52: k+1, or k+2 when the integer part is all ones and
  // the fraction is above one ulp (y rounds past 2^(k+1)).
  // k >= 53: y == mag up to a carry that never changes the result.
  logic [12:0] clog;
  always_comb begin
    logic [5:0]  k;
    logic [51:0] hi_m, lo_m;
    k = 6'd0; hi_m = '0; lo_m = '0;
    if (mag == 63'd0) begin
      clog = 13'd0;
    end else if (ef < 11'd1023) begin
      clog = (ef < 11'd970 || (ef == 11'd970 && mf == 52'd0)) ? 13'd0 : 13'd1;
    end else if (ef >= 11'd1076) begin
      clog = {2'b0, ef} - 13'd1023 + ((mf != 52'd0) ? 13'd1 : 13'd0);
    end else begin
      k = 6'(ef - 11'd1023);               // 0..52
      lo_m = {52{1'b1}} >> k;              // fraction bits below the point
      hi_m = ~lo_m;
      if ((mf & hi_m) == hi_m && (mf & lo_m & ~52'd1) != 52'd0)
        clog = {7'd0, k} + 13'd2;
      else
        clog = {7'd0, k} + 13'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pos <= 6'd0;
    end else begin
      if (cmd.load) begin
        bmin <= in_min;
        bmax <= in_max;
      end
      if (cmd.prep) begin
        mag    <= (bmin[62:0] > bmax[62:0]) ? bmin[62:0] : bmax[62:0];
        nan_f  <= (&bmin[62:52] && bmin[51:0] != 0) || (&bmax[62:52] && bmax[51:0] != 0);
        inf_f  <= (&bmin[62:52] && bmin[51:0] == 0) || (&bmax[62:52] && bmax[51:0] == 0);
        sgn    <= bmin[63] && (bmin[62:0] != 63'd0);
        eq_f   <= (bmin == bmax) || (bmin[62:0] == 63'd0 && bmax[62:0] == 63'd0);
        scan_pos <= 6'd0;
        tz     <= 7'd0;
        tz_hit <= 1'b0;
        blen   <= 7'd0;
      end
      if (cmd.scan) begin
        logic [6:0] tz_v, blen_v;
        logic       hit_v;
        tz_v = tz;
        blen_v = blen;
        hit_v = tz_hit;
        // 8 bits per cycle over the 53-bit significand
        for (int i = 0; i < 8; i++) begin
          logic [5:0] p;
          logic b;
          p = scan_pos + 6'(i);
          b = (p == 6'd52) ? (ef != 11'd0) : ((p < 6'd52) ? mf[p] : 1'b0);
          if (p <= 6'd52) begin
            if (b) blen_v = {1'b0, p} + 7'd1;
            if (!hit_v && !b) tz_v = tz_v + 7'd1;
            if (b) hit_v = 1'b1;
          end
        end
        tz       <= tz_v;
        blen     <= blen_v;
        tz_hit   <= hit_v;
        scan_pos <= scan_pos + 6'd8;
      end
      if (cmd.init) begin
        logic signed [12:0] q, r, room, fl, cap;
        int_bits <= clog + {12'd0, sgn};
        bits     <= {1'b0, start_bits};
        q  = (ef == 11'd0) ? -13'sd1074 : ($signed({2'b0, ef}) - 13'sd1075);
        r  = -(q + $signed({6'd0, tz}));
        cap = (mag == 0 || r < 0) ? 13'sd0 : r;
        fl = (ef == 11'd0) ? ($signed({6'd0, blen}) - 13'sd1075)
                           : ($signed({2'b0, ef}) - 13'sd1023);
        neg_int <= (mag == 0 || fl > 0) ? 13'd0 : -fl;
        room = $signed({6'd0, start_bits}) - $signed(clog + {12'd0, sgn});
        frac <= (eq_f && thr_s < 0 && cap < room) ? cap : room;
        status <= nan_f ? ST_NAN : (inf_f ? ST_INF : ST_OK);
        outsgn <= nan_f ? 1'b1 : sgn;
      end
      if (cmd.grow) begin
        logic [7:0] nb;
        nb = bits + step_w;
        if (nb > {1'b0, maxw}) nb = {1'b0, maxw};
        bits <= nb;
        frac <= {5'd0, nb} - int_bits;
      end
      if (cmd.finish) begin
        if (status == ST_OK && $signed(frac) < thr_s) begin
          frac <= 13'd0;
          status <= ($signed(int_bits) > $signed({5'd0, bits})) ? ST_SHORT_INT : ST_SHORT_FRC;
        end
        if (status != ST_OK) frac <= 13'd0;
      end
    end
  end

  assign sts.special   = nan_f || inf_f;
  assign sts.scan_done = (scan_pos >= 6'd48);
  assign sts.need_grow = ($signed(frac) - $signed(neg_int) < thr_s) &&
                         (bits < {1'b0, maxw});
  assign result = {status, frac[11:0], bits[6:0], outsgn};

  `RFF_ASSERT_NXT(a_grow_mono, clk, rst, cmd.grow, bits >= $past(bits))
  `RFF_ASSERT_IMP(a_one_cmd, clk, rst, 1'b1, $onehot0(cmd))
  `RFF_ASSERT_NXT(a_grow_cap, clk, rst, cmd.grow, bits <= {1'b0, maxw})
endmodule

### src/rff_ctrl.sv
// ----------------------------------------------------------------------------
// rff_ctrl
// Sequencer: capture, classify, significand scan, width search, hand-off.
// ----------------------------------------------------------------------------
module rff_ctrl
  import rff_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic out_free,
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_rdy,
  output logic out_load
);
`include "range_to_fixed_point_format_macros.svh"

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) state_next = S_PREP;
      S_PREP: state_next = S_SCAN;
      S_SCAN: if (sts.scan_done) state_next = S_INIT;
      S_INIT: state_next = S_LOOP;
      S_LOOP: if (sts.special || !sts.need_grow) state_next = S_DONE;
      S_DONE: state_next = S_OUT;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_rdy = 1'b0;
    out_load = 1'b0;
    unique case (state)
      S_IDLE: begin in_rdy = 1'b1; cmd.load = in_fire; end
      S_PREP: cmd.prep = 1'b1;
      S_SCAN: cmd.scan = 1'b1;
      S_INIT: cmd.init = 1'b1;
      S_LOOP: cmd.grow = !sts.special && sts.need_grow;
      S_DONE: cmd.finish = 1'b1;
      S_OUT:  out_load = out_free;
      default: ;
    endcase
  end

  `RFF_ASSERT_IMP(a_rdy_idle, clk, rst, in_rdy, state == S_IDLE)
  `RFF_ASSERT_NXT(a_fire_prep, clk, rst, in_fire, state == S_PREP)
  `RFF_ASSERT_IMP(a_load_out, clk, rst, out_load, state == S_OUT)
endmodule

### src/range_to_fixed_point_format.sv
// ----------------------------------------------------------------------------
// range_to_fixed_point_format
// Picks signedness, width and fractional bits for a double-precision range.
// ----------------------------------------------------------------------------
// channel  | dir | payload
// s_axis   | in  | tdata[63:0] range_min_bits, [127:64] range_max_bits
// m_axis   | out | tdata[0] is_signed, [7:1] total_width, [19:8] frac_bits,
//          |     | [22:20] status
// cfg      | in  | cfg_we, cfg_idx, cfg_data (no read-back)
// One item at a time: capture, classify, significand scan, then the widening steps of the search.
// The significand scan covers 8 bits per cycle.
// Output register lets the next transfer in while a result waits.
// rst is synchronous; it clears the sequencer and the output valid, and sets config to its defaults.
module range_to_fixed_point_format
  import rff_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [127:0]          s_axis_tdata,  // range_min_bits, range_max_bits
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,  // is_signed, total_width, frac_bits, status
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
`include "range_to_fixed_point_format_macros.svh"

  logic [6:0] start_bits, maxw, step;
  logic [7:0] thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_bits <= 7'd32;
      thr        <= 8'd3;
      maxw       <= 7'd64;
      step       <= 7'd8;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_START: start_bits <= cfg_data[6:0];
        REG_THR:   thr        <= cfg_data;
        REG_MAXW:  maxw       <= cfg_data[6:0];
        REG_STEP:  step       <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  cmd_t cmd;
  sts_t sts;
  logic in_rdy, out_load, in_fire, out_free;
  logic [22:0] result;

  assign in_fire = s_axis_tvalid && in_rdy;
  assign s_axis_tready = in_rdy;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  rff_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(out_free),
    .sts(sts), .cmd(cmd), .in_rdy(in_rdy), .out_load(out_load)
  );

  rff_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_min(s_axis_tdata[63:0]), .in_max(s_axis_tdata[127:64]),
    .start_bits(start_bits), .thr_raw(thr), .maxw(maxw), .step_raw(step),
    .result(result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (out_load) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    if (out_load) m_axis_tdata <= {1'b0, result};
  end

  `RFF_ASSERT_NXT(a_out_set, clk, rst, out_load, m_axis_tvalid)
  `RFF_ASSERT_IMP(a_no_overwrite, clk, rst, m_axis_tvalid && !m_axis_tready, !out_load)
  `RFF_ASSERT_IMP(a_pad_zero, clk, rst, m_axis_tvalid, m_axis_tdata[23] == 1'b0)
endmodule

### verif/tb_range_to_fixed_point_format.sv
// ----------------------------------------------------------------------------
// tb_range_to_fixed_point_format
// Self-checking bench for the fixed-point format selector. Range transfers go
// in on s_axis, and every result on m_axis is compared field by field with a
// behavioral format picker. The bench walks several register settings,
// including the extremes, with random idle gaps and stalls on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_range_to_fixed_point_format;
  import rff_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int RAND_ITEMS  = 1100;
  localparam int N_PHASES    = 9;

  typedef struct packed {
    logic       sgn;
    logic [6:0] width;
    logic [11:0] frac;
    logic [2:0] status;
  } fmt_t;

  // Directed stimulus row. has_fmt marks rows whose format is typed in below.
  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
    bit          has_fmt;
    fmt_t        fmt;
  } range_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [23:0]  m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Register shadows, updated at the same edge as the block's copies.
  logic [6:0] start_bits_q = 7'd32;
  logic [7:0] frac_thr_q   = 8'd3;
  logic [6:0] max_width_q  = 7'd64;
  logic [6:0] step_q       = 7'd8;

  fmt_t fmt_q[$];          // formats still owed by the block
  int   n_errors   = 0;
  int   n_results  = 0;
  int   n_sent     = 0;
  int   cycles     = 0;
  int   hold_reqs  = 0;    // long receiver hold-offs asked by the stimulus
  int   hold_done  = 0;
  int   ready_bias = 80;   // percent of cycles the receiver is ready

  range_to_fixed_point_format DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d formats pending", cycles, fmt_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report(input string what);
    n_errors++;
    $display("[%0t] MISMATCH %s", $realtime, what);
  endtask

  // --------------------------------------------------------------------------
  // Format picker
  // --------------------------------------------------------------------------
  function automatic int bit_len(input logic [63:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 64; i++) if (v[i]) n = i + 1;
    return n;
  endfunction

  // binary digits after the point of a finite magnitude, floored at zero
  function automatic int point_digits(input logic [63:0] m);
    logic [63:0] sig;
    int q, tz, r;
    if (m[62:0] == '0) return 0;
    if (m[62:52] == 11'd0) begin
      sig = {12'd0, m[51:0]};
      q = -1074;
    end else begin
      sig = {11'd0, 1'b1, m[51:0]};
      q = int'(m[62:52]) - 1075;
    end
    tz = 0;
    while (!sig[0]) begin
      sig = sig >> 1;
      tz++;
    end
    r = -(q + tz);
    return (r > 0) ? r : 0;
  endfunction

  function automatic fmt_t pick_format(input logic [63:0] lo, input logic [63:0] hi);
    fmt_t f;
    int bits, maxw, stp, thr, frac, int_bits, cap, lead, room;
    logic [63:0] mag, ybits;
    bit lo_nan, hi_nan, lo_inf, hi_inf;
    bits = int'(start_bits_q);
    maxw = int'(max_width_q);
    stp  = (step_q != 0) ? int'(step_q) : 1;
    thr  = int'($signed(frac_thr_q));
    frac = 0;
    f = '0;
    lo_nan = lo[62:52] == 11'h7FF && lo[51:0] != '0;
    hi_nan = hi[62:52] == 11'h7FF && hi[51:0] != '0;
    lo_inf = lo[62:52] == 11'h7FF && lo[51:0] == '0;
    hi_inf = hi[62:52] == 11'h7FF && hi[51:0] == '0;
    if (lo_nan || hi_nan) begin
      f.sgn = 1'b1;
      f.status = ST_NAN;
    end else begin
      f.sgn = $bitstoreal(lo) < 0.0;
      if (lo_inf || hi_inf) begin
        f.status = ST_INF;
      end else begin
        mag = {1'b0, lo[62:0]};
        if ({1'b0, hi[62:0]} > mag) mag = {1'b0, hi[62:0]};
        ybits = $realtobits($bitstoreal(mag) + 1.0);
        int_bits = int'(ybits[62:52]) - 1023 + (ybits[51:0] != '0) + int'(f.sgn);
        if ($bitstoreal(lo) == $bitstoreal(hi) && thr < 0) cap = point_digits(mag);
        else cap = 32'h7FFFFFFF;
        room = bits - int_bits;
        frac = (room < cap) ? room : cap;
        // leading-zero compensation for magnitudes below one
        if (mag == '0) lead = 0;
        else if (mag[62:52] == 11'd0) lead = 1075 - bit_len({12'd0, mag[51:0]});
        else lead = 1023 - int'(mag[62:52]);
        if (lead < 0) lead = 0;
        while (frac - lead < thr && bits < maxw) begin
          bits += stp;
          if (bits > maxw) bits = maxw;
          frac = bits - int_bits;
        end
        if (frac < thr) begin
          frac = 0;
          f.status = (int_bits > bits) ? ST_SHORT_INT : ST_SHORT_FRC;
        end else begin
          f.status = ST_OK;
        end
      end
    end
    f.width = bits[6:0];
    f.frac  = frac[11:0];
    return f;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: predict on input transfer, compare on output transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    fmt_t want, got;
    if (!rst && s_axis_tvalid && s_axis_tready)
      fmt_q.push_back(pick_format(s_axis_tdata[63:0], s_axis_tdata[127:64]));
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      got = {m_axis_tdata[0], m_axis_tdata[7:1], m_axis_tdata[19:8], m_axis_tdata[22:20]};
      if (fmt_q.size() == 0) begin
        report($sformatf("unexpected result %h", m_axis_tdata));
      end else begin
        want = fmt_q.pop_front();
        if (got.sgn !== want.sgn)
          report($sformatf("is_signed %b, want %b", got.sgn, want.sgn));
        if (got.width !== want.width)
          report($sformatf("total_width %0d, want %0d", got.width, want.width));
        if (got.frac !== want.frac)
          report($sformatf("frac_bits %h, want %h", got.frac, want.frac));
        if (got.status !== want.status)
          report($sformatf("status %0d, want %0d", got.status, want.status));
        if (m_axis_tdata[23] !== 1'b0)
          report("pad bit set");
      end
    end
  end

  // Receiver: random ready, occasional long stretches low, and the long
  // hold-offs that the stimulus asks for.
  always @(posedge clk) begin
    int hold_left, gap_left;
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left = 0;
      gap_left = 0;
    end else if (hold_done != hold_reqs) begin
      hold_done <= hold_reqs;
      hold_left = 400;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 199) == 0) begin
      gap_left = $urandom_range(20, 60);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) < ready_bias);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  int send_idle = 1;   // 0: back to back, else gaps allowed

  task automatic send_range(input logic [63:0] lo, input logic [63:0] hi);
    int gap, r;
    r = $urandom_range(0, 99);
    gap = (send_idle == 0 || r < 55) ? 0 : (r < 95) ? $urandom_range(1, 4)
                                                    : $urandom_range(15, 50);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {hi, lo};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    n_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_START: start_bits_q = val[6:0];
      REG_THR:   frac_thr_q   = val;
      REG_MAXW:  max_width_q  = val[6:0];
      default:   step_q       = val[6:0];
    endcase
  endtask

  // Sender stops, and the bench waits for every owed format plus the search
  // latency before the block is touched again.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (fmt_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_bound();
    logic [63:0] v;
    int k;
    k = $urandom_range(0, 99);
    v = {$urandom, $urandom};
    if (k < 15) begin
      // raw pattern
    end else if (k < 22) begin
      // special: zero, infinity or NaN
      case ($urandom_range(0, 2))
        0: v[62:0] = '0;
        1: v[62:0] = {11'h7FF, 52'd0};
        default: v[62:52] = 11'h7FF;
      endcase
      if (v[62:0] == {11'h7FF, 52'd0} && $urandom_range(0, 1)) v[51:0] = 52'd1;
    end else if (k < 30) begin
      v[62:52] = 11'($urandom_range(0, 3));   // subnormal and tiny
    end else if (k < 50) begin
      v = $realtobits(real'($urandom_range(0, 5000)) / real'(1 << $urandom_range(0, 12)));
      v[63] = 1'($urandom_range(0, 1));
    end else begin
      v[62:52] = 11'($urandom_range(1023 - 40, 1023 + 70));
      if ($urandom_range(0, 1)) v[51:0] = v[51:0] & ~(52'hFFFFFFFFFFFFF >> $urandom_range(0, 52));
    end
    return v;
  endfunction

  range_row_t dir_rows[$];

  initial begin
    logic [63:0] lo, hi;
    fmt_t got_fmt;
    int per_phase;

    // Directed rows run with the reset register values.
    dir_rows = '{
      '{64'h7FF8000000000000, 64'h0, 1, '{1'b1, 7'd32, 12'd0, ST_NAN}},
      '{64'h0, 64'hFFFFFFFFFFFFFFFF, 1, '{1'b1, 7'd32, 12'd0, ST_NAN}},
      '{64'h0, 64'h7FF0000000000000, 1, '{1'b0, 7'd32, 12'd0, ST_INF}},
      '{64'hFFF0000000000000, 64'h0, 1, '{1'b1, 7'd32, 12'd0, ST_INF}},
      '{64'hFFF0000000000001, 64'h7FF0000000000000, 1, '{1'b1, 7'd32, 12'd0, ST_NAN}},
      '{64'h0, 64'h0, 0, '0},
      '{64'h8000000000000000, 64'h0, 0, '0},
      '{64'h3FF0000000000000, 64'h3FF0000000000000, 0, '0},
      '{64'hBFF0000000000000, 64'h3FF0000000000000, 0, '0},
      '{64'h7FEFFFFFFFFFFFFF, 64'h7FEFFFFFFFFFFFFF, 0, '0},
      '{64'hFFEFFFFFFFFFFFFF, 64'h0, 0, '0},
      '{64'h0, 64'h0000000000000001, 0, '0},
      '{64'h800FFFFFFFFFFFFF, 64'h0010000000000000, 0, '0},
      '{64'h3FB999999999999A, 64'h3FB999999999999A, 0, '0},
      '{64'h40F869F000000000, 64'h40F869F000000000, 0, '0},
      '{64'hC1E0000000000000, 64'h41DFFFFFFFC00000, 0, '0},
      '{64'h3E80000000000000, 64'h3E90000000000000, 0, '0},
      '{64'h43E0000000000000, 64'h0, 0, '0},
      '{64'h4340000000000000, 64'hC340000000000001, 0, '0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: typed-in formats are checked here as well as by the
    // scoreboard, so a predictor slip cannot hide them.
    foreach (dir_rows[i]) begin
      send_range(dir_rows[i].lo, dir_rows[i].hi);
      if (dir_rows[i].has_fmt) begin
        got_fmt = pick_format(dir_rows[i].lo, dir_rows[i].hi);
        if (got_fmt !== dir_rows[i].fmt) report($sformatf("typed row %0d", i));
      end
    end
    drain();

    per_phase = RAND_ITEMS / N_PHASES;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      // register settings: extremes first, then raw random values
      case (ph)
        0: begin write_reg(REG_START, 8'd1); write_reg(REG_THR, 8'hC0);
                 write_reg(REG_MAXW, 8'd1); write_reg(REG_STEP, 8'd1); end
        1: begin write_reg(REG_START, 8'd64); write_reg(REG_THR, 8'd64);
                 write_reg(REG_MAXW, 8'd64); write_reg(REG_STEP, 8'd64); end
        2: begin write_reg(REG_START, 8'd8); write_reg(REG_THR, 8'hFF);
                 write_reg(REG_MAXW, 8'd64); write_reg(REG_STEP, 8'd1); end
        3: begin write_reg(REG_START, 8'd1); write_reg(REG_THR, 8'd20);
                 write_reg(REG_MAXW, 8'd64); write_reg(REG_STEP, 8'd3); end
        4: begin write_reg(REG_START, 8'h00); write_reg(REG_THR, 8'h80);
                 write_reg(REG_MAXW, 8'h7F); write_reg(REG_STEP, 8'h00); end
        5: begin write_reg(REG_START, 8'h7F); write_reg(REG_THR, 8'h7F);
                 write_reg(REG_MAXW, 8'h00); write_reg(REG_STEP, 8'h7F); end
        default: begin
          write_reg(REG_START, 8'($urandom_range(0, 255)));
          write_reg(REG_THR, 8'($urandom_range(0, 255)));
          write_reg(REG_MAXW, 8'($urandom_range(0, 255)));
          write_reg(REG_STEP, 8'($urandom_range(0, 255)));
        end
      endcase
      cfg_we <= 1'b0;
      @(posedge clk);

      ready_bias = (ph == 1) ? 100 : $urandom_range(30, 95);
      send_idle  = (ph == 1) ? 0 : 1;
      if (ph == 3) hold_reqs++;   // receiver holds off while the sender pushes
      for (int n = 0; n < per_phase; n++) begin
        lo = rand_bound();
        hi = ($urandom_range(0, 99) < 30) ? lo : rand_bound();
        send_range(lo, hi);
        if (ph == 3 && n == 10) send_idle = 0;
      end
      drain();
    end

    $display("Covered %0d range transfers over %0d register settings, %0d formats checked",
             n_sent, N_PHASES + 1, n_results);
    $display("Included NaN, infinite, subnormal, constant and overflowing ranges");
    if (n_errors == 0 && fmt_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d formats pending", n_errors, fmt_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### range_to_fixed_point_format.f
+incdir+src
src/rff_pkg.sv
src/rff_datapath.sv
src/rff_ctrl.sv
src/range_to_fixed_point_format.sv
verif/tb_range_to_fixed_point_format.sv
